@@ hw/rtl/atss_pkg.sv @@
`timescale 1ns / 1ps

package atss_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_SPAN_DEF      = 64;
    localparam int TEX_ADDR_BITS_DEF = 16;

    // Fixed field widths.
    localparam int COORD_W  = 32;
    localparam int LEN_W    = 7;
    localparam int POS_W    = 12;
    localparam int CLIP_W   = 13;
    localparam int TEXEL_W  = 8;
    localparam int IADDR_W  = 16;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    // Rows of the texture are 256 texels wide when no stride is set.
    localparam int FIXED_STRIDE_SHIFT = 8;
    // The destination x cannot go past 4095.
    localparam logic [CLIP_W-1:0] X_LIMIT = 13'd4096;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANSPARENT  = 2'd0,
        CFG_STRIDE       = 2'd1,
        CFG_SCREEN_WIDTH = 2'd2
    } cfg_index_t;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_SPAN = 1'b1;

    // Span start command from the front end to the span generator.
    typedef struct packed {
        logic                start;
        logic [COORD_W-1:0]  u;
        logic [COORD_W-1:0]  v;
        logic [COORD_W-1:0]  du;
        logic [COORD_W-1:0]  dv;
        logic [POS_W-1:0]    x;
        logic [POS_W-1:0]    y;
        logic [LEN_W-1:0]    count;
    } span_cmd_t;

    // Pixel side information that travels alongside the texel address.
    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic             last;
    } pix_info_t;

endpackage

@@ hw/rtl/atss_tex_mem.sv @@
`timescale 1ns / 1ps

module atss_tex_mem #(
    parameter int ADDR_BITS = 16
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_BITS-1:0]          wr_addr,
    input  logic [atss_pkg::TEXEL_W-1:0]  wr_data,
    input  logic                          rd_en,
    input  logic [ADDR_BITS-1:0]          rd_addr,
    output logic [atss_pkg::TEXEL_W-1:0]  rd_data
);
    import atss_pkg::*;

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [TEXEL_W-1:0] mem [DEPTH];
    logic [TEXEL_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // The read data register holds while the consumer stalls.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/atss_span_gen.sv @@
`timescale 1ns / 1ps

module atss_span_gen #(
    parameter int ADDR_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  atss_pkg::span_cmd_t          cmd,
    input  logic                         adv,
    input  logic [atss_pkg::CFG_W-1:0]   row_stride,
    output logic                         busy,
    output atss_pkg::pix_info_t          pix,
    output logic [ADDR_BITS-1:0]         pix_addr
);
    import atss_pkg::*;

    // Stepping stage.
    logic [COORD_W-1:0] u_reg, v_reg, du_reg, dv_reg;
    logic [POS_W-1:0]   x_reg, y_reg;
    logic [LEN_W-1:0]   count_reg;
    logic               g_valid;

    // Row offset stage.
    pix_info_t          s1_reg;
    logic [IADDR_W-1:0] s1_row_reg;
    logic [IADDR_W-1:0] s1_iu_reg;

    // Address stage.
    pix_info_t          s2_reg;
    logic [ADDR_BITS-1:0] s2_addr_reg;

    logic [IADDR_W-1:0]   iu, iv;
    logic [2*IADDR_W-1:0] prod;
    logic [IADDR_W-1:0]   row_next;
    logic [IADDR_W-1:0]   sum16;

    assign g_valid = (count_reg != '0);
    assign iu      = u_reg[COORD_W-1 -: IADDR_W];
    assign iv      = v_reg[COORD_W-1 -: IADDR_W];
    assign prod    = iv * row_stride;

    always_comb
    begin
        if (row_stride == '0)
        begin
            row_next = {iv[IADDR_W-FIXED_STRIDE_SHIFT-1:0], {FIXED_STRIDE_SHIFT{1'b0}}};
        end
        else
        begin
            row_next = prod[IADDR_W-1:0];
        end
    end

    assign sum16 = s1_row_reg + s1_iu_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.start)
        begin
            count_reg <= cmd.count;
        end
        else if (adv && g_valid)
        begin
            count_reg <= count_reg - LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            u_reg  <= cmd.u;
            v_reg  <= cmd.v;
            du_reg <= cmd.du;
            dv_reg <= cmd.dv;
            x_reg  <= cmd.x;
            y_reg  <= cmd.y;
        end
        else if (adv && g_valid)
        begin
            u_reg <= u_reg + du_reg;
            v_reg <= v_reg + dv_reg;
            x_reg <= x_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg      <= '0;
            s1_row_reg  <= '0;
            s1_iu_reg   <= '0;
            s2_reg      <= '0;
            s2_addr_reg <= '0;
        end
        else if (adv)
        begin
            s1_reg.valid <= g_valid;
            s1_reg.x     <= x_reg;
            s1_reg.y     <= y_reg;
            s1_reg.last  <= (count_reg == LEN_W'(1));
            s1_row_reg   <= row_next;
            s1_iu_reg    <= iu;
            s2_reg       <= s1_reg;
            s2_addr_reg  <= sum16[ADDR_BITS-1:0];
        end
    end

    assign busy     = g_valid || s1_reg.valid || s2_reg.valid;
    assign pix      = s2_reg;
    assign pix_addr = s2_addr_reg;

endmodule

@@ hw/rtl/affine_texture_span_sampler.sv @@
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// in        in_valid / in_ready    req_type, texel_address, texel_value, start_u, start_v,
//                                  step_u, step_v, span_length, dest_x, dest_y
// out       out_valid / out_ready  pixel_x, pixel_y, color, write_enable, last
// cfg       cfg_write_en           cfg_index, cfg_data (no wait, no read-back)
//
// A load item is written into the texture memory at acceptance.
// A span item keeps the input closed while any of its pixels is still in the stepping,
// row offset or address stage; an empty or wholly clipped span has no pixels and does not close it at all.
// The texture memory read port delivers one pixel per cycle while the output is not stalled,
// behind a three-stage pipeline (stepping, row offset multiply, address).
// A stalled output freezes the whole pipeline, including the memory read register.
// Reset clears control state only; the texture memory is not cleared and holds garbage
// until written. Configuration registers reset to transparent index 0, stride 0 and screen width 4096.
module affine_texture_span_sampler #(
    parameter int MAX_SPAN      = atss_pkg::MAX_SPAN_DEF,
    parameter int TEX_ADDR_BITS = atss_pkg::TEX_ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              req_type,
    input  logic [atss_pkg::IADDR_W-1:0]      texel_address,
    input  logic [atss_pkg::TEXEL_W-1:0]      texel_value,
    input  logic signed [atss_pkg::COORD_W-1:0] start_u,
    input  logic signed [atss_pkg::COORD_W-1:0] start_v,
    input  logic signed [atss_pkg::COORD_W-1:0] step_u,
    input  logic signed [atss_pkg::COORD_W-1:0] step_v,
    input  logic [atss_pkg::LEN_W-1:0]        span_length,
    input  logic [atss_pkg::POS_W-1:0]        dest_x,
    input  logic [atss_pkg::POS_W-1:0]        dest_y,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [atss_pkg::POS_W-1:0]        pixel_x,
    output logic [atss_pkg::POS_W-1:0]        pixel_y,
    output logic [atss_pkg::TEXEL_W-1:0]      color,
    output logic                              write_enable,
    output logic                              last,
    input  logic                              cfg_write_en,
    input  logic [atss_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [atss_pkg::CFG_W-1:0]        cfg_data
);
    import atss_pkg::*;

    // Configuration registers.
    logic [TEXEL_W-1:0] transparent_reg;
    logic [CFG_W-1:0]   stride_reg;
    logic [CLIP_W-1:0]  screen_width_reg;

    // Output stage; the color comes straight from the memory read register.
    logic             out_valid_reg;
    logic [POS_W-1:0] out_x_reg, out_y_reg;
    logic             out_last_reg;

    logic             accept;
    logic             adv;
    logic             gen_busy;
    span_cmd_t        cmd;
    pix_info_t        pix;
    logic [TEX_ADDR_BITS-1:0] pix_addr;
    logic [TEXEL_W-1:0] rd_data;

    logic [LEN_W-1:0]  len_sat;
    logic [CLIP_W-1:0] clip;
    logic [CLIP_W-1:0] x_ext;
    logic [CLIP_W-1:0] room;
    logic [LEN_W-1:0]  n_pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            transparent_reg  <= '0;
            stride_reg       <= '0;
            screen_width_reg <= X_LIMIT;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_TRANSPARENT:  transparent_reg  <= cfg_data[TEXEL_W-1:0];
                CFG_STRIDE:       stride_reg       <= cfg_data;
                CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data[CLIP_W-1:0];
                default: ;
            endcase
        end
    end

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv = !out_valid_reg || out_ready;

    // A new item waits until no earlier pixel still has to read the texture, so a load
    // never overtakes a pending read. A finished pixel may still wait at the output.
    assign in_ready = !gen_busy;
    assign accept   = in_valid && in_ready;

    // Pixel count of a span: the length saturated to the span limit and cut at the clip.
    always_comb
    begin
        len_sat = (span_length > LEN_W'(MAX_SPAN)) ? LEN_W'(MAX_SPAN) : span_length;
        clip    = (screen_width_reg > X_LIMIT) ? X_LIMIT : screen_width_reg;
        x_ext   = {1'b0, dest_x};
        room    = clip - x_ext;
        if (x_ext >= clip)
        begin
            n_pix = '0;
        end
        else if (CLIP_W'(len_sat) < room)
        begin
            n_pix = len_sat;
        end
        else
        begin
            n_pix = room[LEN_W-1:0];
        end
    end

    always_comb
    begin
        cmd.start = accept && (req_type == REQ_SPAN);
        cmd.u     = start_u;
        cmd.v     = start_v;
        cmd.du    = step_u;
        cmd.dv    = step_v;
        cmd.x     = dest_x;
        cmd.y     = dest_y;
        cmd.count = n_pix;
    end

    atss_span_gen #(
        .ADDR_BITS (TEX_ADDR_BITS)
    ) u_span_gen (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .adv        (adv),
        .row_stride (stride_reg),
        .busy       (gen_busy),
        .pix        (pix),
        .pix_addr   (pix_addr)
    );

    atss_tex_mem #(
        .ADDR_BITS (TEX_ADDR_BITS)
    ) u_tex_mem (
        .clk     (clk),
        .wr_en   (accept && (req_type == REQ_LOAD)),
        .wr_addr (texel_address[TEX_ADDR_BITS-1:0]),
        .wr_data (texel_value),
        .rd_en   (adv),
        .rd_addr (pix_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg    <= pix.x;
            out_y_reg    <= pix.y;
            out_last_reg <= pix.last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = out_x_reg;
    assign pixel_y      = out_y_reg;
    assign color        = rd_data;
    assign write_enable = (rd_data != transparent_reg);
    assign last         = out_last_reg;

`ifndef NO_ASSERTIONS
    // A load item never produces a result on its own.
    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (req_type == REQ_LOAD) && !out_valid) |=> !out_valid)
        else $error("load item produced a result");

    // Within a span the pipeline stays packed: a taken non-final pixel is followed at once.
    a_span_packed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last) |=> out_valid)
        else $error("gap inside a span");

    // After the final pixel of a span the next span needs the pipeline to refill.
    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last) |=> !out_valid)
        else $error("result right after the final pixel of a span");
`endif

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import atss_pkg::*;

    // The run is bounded by this many clock cycles; a correct run needs far fewer.
    localparam int LIMIT_CYCLES  = 600000;
    // Quiet cycles after the last pixel before a register write or the end of the run.
    // A span that is wholly clipped emits nothing and leaves the block at once; the
    // pause gives any stray extra pixel time to show up.
    localparam int SETTLE_CYCLES = 80;
    // Random items per configuration phase; six phases plus the directed part
    // make roughly 470 items in all.
    localparam int PHASE_ITEMS   = 75;
    localparam int NUM_PHASES    = 6;
    localparam int MAX_SPAN      = MAX_SPAN_DEF;
    localparam int TEX_BITS      = TEX_ADDR_BITS_DEF;
    localparam logic [15:0] ADDR_MASK = 16'((32'd1 << TEX_BITS) - 1);

    // One input item as it crosses the input handshake.
    typedef struct {
        logic        req;
        logic [15:0] taddr;
        logic [7:0]  tval;
        logic [31:0] su;
        logic [31:0] sv;
        logic [31:0] du;
        logic [31:0] dv;
        logic [6:0]  len;
        logic [11:0] x0;
        logic [11:0] y0;
    } sampler_req_t;

    // One emitted pixel.
    typedef struct {
        logic [11:0] x;
        logic [11:0] y;
        logic [7:0]  color;
        logic        we;
        logic        last;
    } pixel_t;

    // Holds a private copy of the texture and of the registers, predicts the pixels
    // of every accepted span and checks the emitted pixels in order.
    class pixel_scoreboard;
        logic [7:0]  texels [65536];
        bit          written [65536];
        logic [7:0]  transparent;
        logic [15:0] stride;
        logic [12:0] screen_width;
        pixel_t      pending_pixels [$];
        int          errors;

        function new();
            transparent  = 8'd0;
            stride       = 16'd0;
            screen_width = 13'd4096;
            errors       = 0;
            foreach (written[i])
                written[i] = 1'b0;
        endfunction

        function void write_reg(cfg_index_t idx, logic [15:0] data);
            case (idx)
                CFG_TRANSPARENT:  transparent  = data[7:0];
                CFG_STRIDE:       stride       = data;
                CFG_SCREEN_WIDTH: screen_width = data[12:0];
                default:          ;
            endcase
        endfunction

        // The right clip never lies past 4096, since x cannot exceed 4095.
        function int clip_x();
            return (screen_width < X_LIMIT) ? int'(screen_width) : int'(X_LIMIT);
        endfunction

        // Integer parts are raw 16-bit patterns, so negative coordinates wrap.
        function logic [15:0] texel_addr(logic [31:0] u, logic [31:0] v);
            logic [31:0] sum;
            if (stride == 16'd0)
                sum = {16'd0, v[31:16]} << FIXED_STRIDE_SHIFT;
            else
                sum = {16'd0, v[31:16]} * {16'd0, stride};
            sum = sum + {16'd0, u[31:16]};
            return sum[15:0] & ADDR_MASK;
        endfunction

        // Pixels a span emits: its length saturated to MAX_SPAN, cut at the clip.
        function int visible_pixels(sampler_req_t r);
            int len;
            int room;
            len  = (r.len > MAX_SPAN) ? MAX_SPAN : int'(r.len);
            room = clip_x() - int'(r.x0);
            if (room < 0)
                room = 0;
            return (len < room) ? len : room;
        endfunction

        function int pending();
            return pending_pixels.size();
        endfunction

        function void note_request(sampler_req_t r);
            int          n;
            logic [31:0] u;
            logic [31:0] v;
            pixel_t      p;
            if (r.req == REQ_LOAD) begin
                texels[r.taddr & ADDR_MASK]  = r.tval;
                written[r.taddr & ADDR_MASK] = 1'b1;
                return;
            end
            n = visible_pixels(r);
            u = r.su;
            v = r.sv;
            for (int i = 0; i < n; i++) begin
                p.x     = r.x0 + 12'(i);
                p.y     = r.y0;
                p.color = texels[texel_addr(u, v)];
                p.we    = (p.color != transparent);
                p.last  = (i == n - 1);
                pending_pixels.push_back(p);
                u = u + r.du;
                v = v + r.dv;
            end
        endfunction

        function void compare(string field, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, field, want, got);
            end
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0) begin
                errors++;
                $display("%0t: unexpected pixel, expected none, actual x=%0d y=%0d",
                         $time, got.x, got.y);
                return;
            end
            want = pending_pixels.pop_front();
            compare("pixel_x", 32'(want.x), 32'(got.x));
            compare("pixel_y", 32'(want.y), 32'(got.y));
            compare("color", 32'(want.color), 32'(got.color));
            compare("write_enable", 32'(want.we), 32'(got.we));
            compare("last", 32'(want.last), 32'(got.last));
        endfunction
    endclass

    // Every input of the block holds a known value from time zero.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        req_type = REQ_LOAD;
    logic [15:0] texel_address = 16'd0;
    logic [7:0]  texel_value = 8'd0;
    logic [31:0] start_u = 32'd0;
    logic [31:0] start_v = 32'd0;
    logic [31:0] step_u = 32'd0;
    logic [31:0] step_v = 32'd0;
    logic [6:0]  span_length = 7'd0;
    logic [11:0] dest_x = 12'd0;
    logic [11:0] dest_y = 12'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  color;
    logic        write_enable;
    logic        last;
    logic        cfg_write_en = 1'b0;
    cfg_index_t  cfg_index = CFG_TRANSPARENT;
    logic [15:0] cfg_data = 16'd0;

    pixel_scoreboard sb = new();

    // When set, neither side inserts idle cycles; one whole phase runs this way.
    bit          no_gaps = 1'b0;
    int          items_sent = 0;
    int          cycle_count = 0;
    // Address read by the first pixel of the latest span; noise loads rewrite it
    // to catch a load that overtakes a span still in the read pipeline.
    logic [15:0] last_read = 16'd0;

    affine_texture_span_sampler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .texel_address (texel_address),
        .texel_value   (texel_value),
        .start_u       (start_u),
        .start_v       (start_v),
        .step_u        (step_u),
        .step_v        (step_v),
        .span_length   (span_length),
        .dest_x        (dest_x),
        .dest_y        (dest_y),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .color         (color),
        .write_enable  (write_enable),
        .last          (last),
        .cfg_write_en  (cfg_write_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // The watchdog ends a run that hangs.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // The receiver stalls about 30 percent of the time, except in the gap-free phase.
    always @(negedge clk)
    begin
        out_ready <= no_gaps || ($urandom_range(99) >= 30);
    end

    // Both handshakes are observed at the rising edge. An accepted input item goes
    // to the predictor; an accepted pixel is checked against the oldest prediction.
    always @(posedge clk)
    begin : monitor
        sampler_req_t seen_req;
        pixel_t       seen_pix;
        if (rst_n && in_valid && in_ready) begin
            seen_req.req   = req_type;
            seen_req.taddr = texel_address;
            seen_req.tval  = texel_value;
            seen_req.su    = start_u;
            seen_req.sv    = start_v;
            seen_req.du    = step_u;
            seen_req.dv    = step_v;
            seen_req.len   = span_length;
            seen_req.x0    = dest_x;
            seen_req.y0    = dest_y;
            sb.note_request(seen_req);
        end
        if (rst_n && out_valid && out_ready) begin
            seen_pix.x     = pixel_x;
            seen_pix.y     = pixel_y;
            seen_pix.color = color;
            seen_pix.we    = write_enable;
            seen_pix.last  = last;
            sb.check_pixel(seen_pix);
        end
    end

    // A load item; the span fields are don't-care and carry random bits.
    function automatic sampler_req_t load_req(logic [15:0] a, logic [7:0] val);
        sampler_req_t r;
        r.req   = REQ_LOAD;
        r.taddr = a;
        r.tval  = val;
        r.su    = $urandom;
        r.sv    = $urandom;
        r.du    = $urandom;
        r.dv    = $urandom;
        r.len   = 7'($urandom);
        r.x0    = 12'($urandom);
        r.y0    = 12'($urandom);
        return r;
    endfunction

    // A span item; the load fields are don't-care and carry random bits.
    function automatic sampler_req_t span_req(logic [31:0] su, logic [31:0] sv,
                                              logic [31:0] du, logic [31:0] dv,
                                              logic [6:0] len, logic [11:0] x0,
                                              logic [11:0] y0);
        sampler_req_t r;
        r.req   = REQ_SPAN;
        r.taddr = 16'($urandom);
        r.tval  = 8'($urandom);
        r.su    = su;
        r.sv    = sv;
        r.du    = du;
        r.dv    = dv;
        r.len   = len;
        r.x0    = x0;
        r.y0    = y0;
        return r;
    endfunction

    // A quarter of the loaded texels hit the transparent index.
    function automatic logic [7:0] fresh_texel();
        return ($urandom_range(3) == 0) ? sb.transparent : 8'($urandom);
    endfunction

    function automatic logic [31:0] signed_step(int unsigned mag);
        logic [31:0] s;
        s = $urandom_range(mag, 0);
        return ($urandom_range(1) == 1) ? -s : s;
    endfunction

    function automatic logic [6:0] random_length();
        int k;
        k = $urandom_range(99);
        if (k < 5)
            return 7'd0;
        else if (k < 15)
            return 7'($urandom_range(127, 65));
        else
            return 7'($urandom_range(64, 1));
    endfunction

    // Drives one item at the falling edge and holds it until it is accepted.
    // Returns at the falling edge after acceptance with the valid still high,
    // so a following item can go out back to back.
    task automatic send_item(sampler_req_t r);
        if (!no_gaps && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge clk);
        end
        in_valid      <= 1'b1;
        req_type      <= r.req;
        texel_address <= r.taddr;
        texel_value   <= r.tval;
        start_u       <= r.su;
        start_v       <= r.sv;
        step_u        <= r.du;
        step_v        <= r.dv;
        span_length   <= r.len;
        dest_x        <= r.x0;
        dest_y        <= r.y0;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Loads every texel that the span will read and that has never been written,
    // then issues the span. A texel that was never written is never read.
    task automatic draw_span(sampler_req_t r);
        int          n;
        logic [31:0] u;
        logic [31:0] v;
        logic [15:0] a;
        n = sb.visible_pixels(r);
        u = r.su;
        v = r.sv;
        for (int i = 0; i < n; i++) begin
            a = sb.texel_addr(u, v);
            if (!sb.written[a])
                send_item(load_req(a, fresh_texel()));
            u = u + r.du;
            v = v + r.dv;
        end
        send_item(r);
        last_read = sb.texel_addr(r.su, r.sv);
    endtask

    // Drains the block: no input, every predicted pixel delivered, then a pause
    // in which any stray extra pixel can still show up.
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_config(cfg_index_t idx, logic [15:0] data);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_write_en <= 1'b0;
        @(negedge clk);
    endtask

    // One random item. The largest share are spans with small steps around a home
    // coordinate, so the texels they need are mostly loaded already; the rest are spans
    // from random starts, spans with wild steps, spans at the clip, and stray loads.
    task automatic random_item(logic [31:0] home_u, logic [31:0] home_v);
        sampler_req_t r;
        int           pick;
        int           clip;
        logic [15:0]  a;
        logic [11:0]  x0;
        pick = $urandom_range(99);
        clip = sb.clip_x();
        if ($urandom_range(3) == 0 || clip == 0)
            x0 = 12'($urandom);
        else
            x0 = 12'($urandom_range(clip - 1, 0));
        if (pick < 12) begin
            a = ($urandom_range(1) == 1) ? last_read : 16'($urandom);
            send_item(load_req(a, 8'($urandom)));
        end else if (pick < 55) begin
            r = span_req(home_u + signed_step(32'h0004_0000),
                         home_v + signed_step(32'h0004_0000),
                         signed_step(32'h1000), signed_step(32'h1000),
                         random_length(), x0, 12'($urandom));
            draw_span(r);
        end else if (pick < 80) begin
            r = span_req($urandom, $urandom,
                         signed_step(($urandom_range(3) == 0) ? 32'h8000 : 32'h0C00),
                         signed_step(32'h0C00),
                         random_length(), x0, 12'($urandom));
            draw_span(r);
        end else if (pick < 92) begin
            r = span_req($urandom, $urandom, $urandom, $urandom,
                         7'($urandom_range(6, 1)), x0, 12'($urandom));
            draw_span(r);
        end else begin
            // Start just left of the clip or beyond it.
            x0 = 12'((clip > 40) ? $urandom_range(clip + 4, clip - 40)
                                 : $urandom_range(44, 0));
            r = span_req(home_u, home_v, signed_step(32'h0800), signed_step(32'h0800),
                         7'($urandom_range(127, 0)), x0, 12'($urandom));
            draw_span(r);
        end
    endtask

    initial
    begin : stimulus
        int          target;
        logic [31:0] home_u;
        logic [31:0] home_v;
        logic [7:0]  trans_sel;
        logic [15:0] stride_sel;
        logic [12:0] width_sel;

        // Asynchronous reset is held from time zero and released at a falling edge.
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part, starting from the reset configuration: transparent index 0,
        // fixed 256 stride, full-width clip. Texels at both ends of the store first.
        send_item(load_req(16'h0000, 8'h00));
        send_item(load_req(16'hFFFF, 8'hFF));
        send_item(load_req(16'h0101, 8'h5A));
        // A single pixel on the transparent index: write_enable stays low.
        draw_span(span_req(32'd0, 32'd0, 32'd0, 32'd0, 7'd1, 12'd0, 12'd0));
        // Negative coordinates wrap into the texture; only x=4095 is on screen.
        draw_span(span_req(32'hFFFF_8000, 32'hFFFF_0000, 32'd0, 32'd0,
                           7'd3, 12'd4095, 12'd4095));
        // A length above the maximum saturates to 64 pixels.
        draw_span(span_req(32'h0001_8000, 32'h0001_0000, 32'd0, 32'd0,
                           7'd127, 12'd100, 12'h5A5));
        // An empty span emits nothing.
        draw_span(span_req(32'd0, 32'd0, 32'd0, 32'd0, 7'd0, 12'd0, 12'd1));
        // Huge steps: the u step carries the 32-bit coordinate past its signed maximum.
        draw_span(span_req(32'h7FFF_0000, 32'd0, 32'h7FFF_FFFF, 32'h8000_0001,
                           7'd2, 12'd2000, 12'd2));

        // A narrow screen clips a span in the middle and kills one at the edge.
        settle();
        write_config(CFG_SCREEN_WIDTH, 16'd10);
        write_config(CFG_TRANSPARENT, 16'h005A);
        draw_span(span_req(32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0,
                           7'd20, 12'd5, 12'd7));
        draw_span(span_req(32'd0, 32'd0, 32'd0, 32'd0, 7'd4, 12'd10, 12'd7));

        // A zero screen width suppresses every pixel.
        settle();
        write_config(CFG_SCREEN_WIDTH, 16'd0);
        draw_span(span_req(32'd0, 32'd0, 32'd0, 32'd0, 7'd64, 12'd0, 12'd8));

        // A screen width above 4096 clips at 4096. With the widest stride, row 1
        // column 1 wraps to address 0. A load then rewrites that texel right
        // behind the span, and the next span must see the new value.
        settle();
        write_config(CFG_SCREEN_WIDTH, 16'h1FFF);
        write_config(CFG_STRIDE, 16'hFFFF);
        draw_span(span_req(32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0,
                           7'd64, 12'd4090, 12'd9));
        send_item(load_req(16'h0000, 8'hC3));
        draw_span(span_req(32'h0001_0000, 32'h0001_0000, 32'd0, 32'd0,
                           7'd3, 12'd0, 12'd10));

        // Random phases, each under its own register setting. The first two take
        // the extremes; phase 3 runs with no idle cycles on either side.
        target = items_sent;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            settle();
            case (phase)
                0: begin
                    trans_sel  = 8'hFF;
                    stride_sel = 16'd0;
                    width_sel  = 13'h1FFF;
                end
                1: begin
                    trans_sel  = 8'h00;
                    stride_sel = 16'hFFFF;
                    width_sel  = 13'd4096;
                end
                default: begin
                    trans_sel  = 8'($urandom);
                    case ($urandom_range(4))
                        0: stride_sel = 16'd0;
                        1: stride_sel = 16'd1;
                        2: stride_sel = 16'd256;
                        3: stride_sel = 16'($urandom_range(600, 2));
                        default: stride_sel = 16'($urandom);
                    endcase
                    case ($urandom_range(3))
                        0: width_sel = 13'($urandom_range(700, 64));
                        1: width_sel = 13'($urandom_range(4096, 1));
                        2: width_sel = 13'($urandom_range(8191, 4097));
                        default: width_sel = 13'd4096;
                    endcase
                end
            endcase
            // Bits above the transparent and screen width registers are random and must be ignored.
            write_config(CFG_TRANSPARENT, {8'($urandom), trans_sel});
            write_config(CFG_STRIDE, stride_sel);
            write_config(CFG_SCREEN_WIDTH, {3'($urandom), width_sel});
            no_gaps = (phase == 3);
            home_u  = $urandom;
            home_v  = $urandom;
            target  = target + PHASE_ITEMS;
            while (items_sent < target)
                random_item(home_u, home_v);
        end

        no_gaps = 1'b0;
        settle();
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
